// ----- sv/sxf_pkg.sv -----
`default_nettype none

package sxf_pkg;

	localparam int SCREEN_WIDTH  = 64;
	localparam int SCREEN_HEIGHT = 32;

	localparam int COL_W = $clog2(SCREEN_WIDTH);
	localparam int ROW_W = $clog2(SCREEN_HEIGHT);

	localparam int SPRITE_COLS = 8;
	localparam int ROFF_DEPTH  = 16;

	// action codes
	localparam logic ACT_DRAW = 1'b0;
	localparam logic ACT_READ = 1'b1;

	typedef logic [COL_W-1:0]        col_t;
	typedef logic [ROW_W-1:0]        row_t;
	typedef logic [SCREEN_WIDTH-1:0] line_t;

	// Reduction tables, built at elaboration.
	function automatic logic [255:0][COL_W-1:0] gen_col_tab();
		logic [255:0][COL_W-1:0] t;
		for (int i = 0; i < 256; i++) begin
			t[i] = COL_W'(i % SCREEN_WIDTH);
		end
		return t;
	endfunction

	function automatic logic [255:0][ROW_W-1:0] gen_row_tab();
		logic [255:0][ROW_W-1:0] t;
		for (int i = 0; i < 256; i++) begin
			t[i] = ROW_W'(i % SCREEN_HEIGHT);
		end
		return t;
	endfunction

	function automatic logic [ROFF_DEPTH-1:0][ROW_W-1:0] gen_roff_tab();
		logic [ROFF_DEPTH-1:0][ROW_W-1:0] t;
		for (int i = 0; i < ROFF_DEPTH; i++) begin
			t[i] = ROW_W'(i % SCREEN_HEIGHT);
		end
		return t;
	endfunction

	localparam logic [255:0][COL_W-1:0]        COL_TAB  = gen_col_tab();
	localparam logic [255:0][ROW_W-1:0]        ROW_TAB  = gen_row_tab();
	localparam logic [ROFF_DEPTH-1:0][ROW_W-1:0] ROFF_TAB = gen_roff_tab();

	// Operands already below the modulus, so one compare and subtract.
	function automatic col_t col_wrap(logic [COL_W:0] s);
		logic [COL_W:0] r;
		r = s;
		if (s >= (COL_W+1)'(SCREEN_WIDTH)) begin
			r = s - (COL_W+1)'(SCREEN_WIDTH);
		end
		return r[COL_W-1:0];
	endfunction

	function automatic row_t row_wrap(logic [ROW_W:0] s);
		logic [ROW_W:0] r;
		r = s;
		if (s >= (ROW_W+1)'(SCREEN_HEIGHT)) begin
			r = s - (ROW_W+1)'(SCREEN_HEIGHT);
		end
		return r[ROW_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ----- sv/sxf_if.sv -----
`default_nettype none

interface sxf_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] x_pos;
	logic [7:0] y_pos;
	logic [3:0] row_offset;
	logic [7:0] row_bits;
	logic       first_row;
	logic       last_row;

	modport source (
		output valid, action, x_pos, y_pos, row_offset, row_bits, first_row, last_row,
		input  ready
	);
	modport sink (
		input  valid, action, x_pos, y_pos, row_offset, row_bits, first_row, last_row,
		output ready
	);
endinterface

interface sxf_out_if;
	logic valid;
	logic ready;
	logic collision;
	logic pixel_value;
	logic draw_done;

	modport source (
		output valid, collision, pixel_value, draw_done,
		input  ready
	);
	modport sink (
		input  valid, collision, pixel_value, draw_done,
		output ready
	);
endinterface

`default_nettype wire

// ----- sv/sprite_xor_framebuffer_core.sv -----
`default_nettype none

// Monochrome SCREEN_WIDTH x SCREEN_HEIGHT framebuffer (64x32) with the classic
// sprite XOR draw. Each req transfer is either one sprite row (action draw) or
// one pixel read (action read), and yields exactly one rsp transfer. A draw
// toggles the pixels of the set bits of row_bits (bit 7 leftmost) at
// ((x_pos+col) mod width, (y_pos+row_offset) mod height), wrapping pixel by
// pixel; collision is cleared by first_row and set when a lit pixel is erased,
// and the rsp carries the running flag with draw_done = last_row. A read
// returns the pixel at (x_pos mod width, y_pos mod height) and the current flag.
// Throughput is one transfer per cycle while rsp is not stalled: the frame
// is held as one word per screen row, so every item is a single row-wide
// read-modify-write; a write is forwarded to the item right behind it. An
// item passes stage 1, then the result register. After reset the frame reads
// as all dark at once (per-row valid bits), no clearing pass is needed.
module sprite_xor_framebuffer_core
	import sxf_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	sxf_in_if.sink      req,
	sxf_out_if.source   rsp
);

	// ---------------------------------------------------------------
	// Input side: row address for the memory read at transfer time
	// ---------------------------------------------------------------
	logic           fire_s1;
	logic           acc;
	row_t           rd_row;
	logic [ROW_W:0] row_sum;

	assign acc = req.valid && req.ready;

	// y and row_offset are each reduced first, so the sum is below 2*height
	assign row_sum = {1'b0, ROW_TAB[req.y_pos]} + {1'b0, ROFF_TAB[req.row_offset]};

	always_comb begin
		if (req.action == ACT_READ) begin
			rd_row = ROW_TAB[req.y_pos];
		end else begin
			rd_row = row_wrap(row_sum);
		end
	end

	// ---------------------------------------------------------------
	// Stage 1 registers: the accepted item
	// ---------------------------------------------------------------
	logic       vld_s1;
	logic       act_s1;
	logic [7:0] x_s1;
	logic [7:0] bits_s1;
	logic       first_s1;
	logic       last_s1;
	row_t       row_s1;

	assign req.ready = !vld_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (acc) begin
			vld_s1 <= 1'b1;
		end else if (fire_s1) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			act_s1   <= req.action;
			x_s1     <= req.x_pos;
			bits_s1  <= req.row_bits;
			first_s1 <= req.first_row;
			last_s1  <= req.last_row;
			row_s1   <= rd_row;
		end
	end

	// ---------------------------------------------------------------
	// Frame memory: one word per screen row, read registered
	// ---------------------------------------------------------------
	line_t                   mem_q [SCREEN_HEIGHT];
	line_t                   rd_q;
	logic [SCREEN_HEIGHT-1:0] row_vld_q;
	logic                    rdv_q;
	logic                    wr_en;
	line_t                   wr_data;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[row_s1] <= wr_data;
		end
		if (acc) begin
			rd_q <= mem_q[rd_row];
		end
	end

	// A row never written since reset reads as dark.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rdv_q     <= 1'b0;
		end else begin
			if (wr_en) begin
				row_vld_q[row_s1] <= 1'b1;
			end
			if (acc) begin
				rdv_q <= row_vld_q[rd_row];
			end
		end
	end

	// Last write kept for forwarding: it is always the current content of
	// its row, so a hit on it overrides the (possibly stale) read data.
	logic  fwd_vld_q;
	row_t  fwd_row_q;
	line_t fwd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= 1'b0;
		end else if (wr_en) begin
			fwd_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_row_q  <= row_s1;
			fwd_data_q <= wr_data;
		end
	end

	// ---------------------------------------------------------------
	// Stage 1 logic: toggle mask, collision, pixel pick
	// ---------------------------------------------------------------
	line_t row_now;
	line_t mask;
	col_t  xb;
	logic  coll_q;
	logic  coll_nxt;
	logic  pix;

	assign xb = COL_TAB[x_s1];

	always_comb begin
		if (fwd_vld_q && (fwd_row_q == row_s1)) begin
			row_now = fwd_data_q;
		end else if (rdv_q) begin
			row_now = rd_q;
		end else begin
			row_now = '0;
		end
	end

	// bit 7 of the row byte is the leftmost sprite column
	always_comb begin
		mask = '0;
		for (int c = 0; c < SPRITE_COLS; c++) begin
			if (bits_s1[SPRITE_COLS-1-c]) begin
				mask[col_wrap({1'b0, xb} + (COL_W+1)'(c))] = 1'b1;
			end
		end
	end

	assign wr_data  = row_now ^ mask;
	assign coll_nxt = (first_s1 ? 1'b0 : coll_q) | (|(row_now & mask));
	assign pix      = row_now[xb];
	assign wr_en    = fire_s1 && (act_s1 == ACT_DRAW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coll_q <= 1'b0;
		end else if (wr_en) begin
			coll_q <= coll_nxt;
		end
	end

	// ---------------------------------------------------------------
	// Result register
	// ---------------------------------------------------------------
	logic out_vld_q;
	logic out_coll_q;
	logic out_pix_q;
	logic out_done_q;

	assign fire_s1 = vld_s1 && (!out_vld_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (fire_s1) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			if (act_s1 == ACT_READ) begin
				out_coll_q <= coll_q;
				out_pix_q  <= pix;
				out_done_q <= 1'b0;
			end else begin
				out_coll_q <= coll_nxt;
				out_pix_q  <= 1'b0;
				out_done_q <= last_s1;
			end
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.collision   = out_coll_q;
	assign rsp.pixel_value = out_pix_q;
	assign rsp.draw_done   = out_done_q;

`ifndef SYNTHESIS
	// A result is never both a read with a lit pixel and an end-of-sprite draw.
	a_rsp_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.pixel_value && rsp.draw_done))
		else $error("rsp carries both pixel_value and draw_done");

	// Back-pressure only comes from a full result register that is not drained.
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (vld_s1 && out_vld_q && !rsp.ready))
		else $error("req stalled without a blocked result");

	// An empty first row leaves the flag cleared.
	a_first_clr: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && first_s1 && (bits_s1 == 8'h00)) |=> !coll_q)
		else $error("collision flag not cleared by empty first row");
`endif

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
`default_nettype none

module testbench;
	import sxf_pkg::*;

	typedef struct {
		logic       action;
		logic [7:0] x_pos;
		logic [7:0] y_pos;
		logic [3:0] row_offset;
		logic [7:0] row_bits;
		logic       first_row;
		logic       last_row;
		bit         wait_drain;	// hold this item back until all results are in
	} sprite_item_t;

	typedef struct packed {
		logic collision;
		logic pixel_value;
		logic draw_done;
	} pixel_rsp_t;

	localparam int RSP_HOLD_AT     = 400;	// results seen before the long sink stall
	localparam int RSP_HOLD_CYCLES = 300;
	localparam int CALM_LO         = 900;	// window with no idling on either side
	localparam int CALM_HI         = 1100;
	localparam int RANDOM_ITEMS    = 1200;

	logic clk;
	logic arst_n;

	sxf_in_if  req_if ();
	sxf_out_if rsp_if ();

	sprite_xor_framebuffer_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// Shadow of the screen: one word per screen row, bit index is the column.
	line_t        screen_lines [SCREEN_HEIGHT];
	logic         shadow_collision;

	sprite_item_t pending_items [$];
	pixel_rsp_t   expected_rsp [$];
	sprite_item_t cur_item;

	int items_accepted;
	int results_seen;
	int error_count;
	int draw_count;
	int read_count;
	int collision_hits;
	int lit_reads;
	int hold_left;
	bit hold_done;

	// Last random sprite, kept so it can be redrawn to erase it again.
	logic [7:0] sprite_x;
	logic [7:0] sprite_y;
	logic [7:0] sprite_rows [$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Runs one item against the shadow screen and returns what the block
	// should answer. Updates the shadow state for draws.
	function automatic pixel_rsp_t apply_sprite_item(sprite_item_t it);
		pixel_rsp_t r;
		int         line;
		int         col;
		r = '0;
		if (it.action == ACT_READ) begin
			line = int'(it.y_pos) % SCREEN_HEIGHT;
			col = int'(it.x_pos) % SCREEN_WIDTH;
			r.collision = shadow_collision;
			r.pixel_value = screen_lines[line][col];
			return r;
		end
		// first_row clears the flag even when the row byte is empty
		if (it.first_row)
			shadow_collision = 1'b0;
		line = (int'(it.y_pos) + int'(it.row_offset)) % SCREEN_HEIGHT;
		for (int c = 0; c < 8; c++) begin
			if (it.row_bits[7-c]) begin
				col = (int'(it.x_pos) + c) % SCREEN_WIDTH;
				if (screen_lines[line][col])
					shadow_collision = 1'b1;
				screen_lines[line][col] = ~screen_lines[line][col];
			end
		end
		r.collision = shadow_collision;
		r.draw_done = it.last_row;	// last_row is only echoed, no effect on state
		return r;
	endfunction

	task automatic queue_item(input logic act, input logic [7:0] x, input logic [7:0] y,
			input logic [3:0] roff, input logic [7:0] bits, input logic fr, input logic lr);
		sprite_item_t it;
		it.action = act;
		it.x_pos = x;
		it.y_pos = y;
		it.row_offset = roff;
		it.row_bits = bits;
		it.first_row = fr;
		it.last_row = lr;
		it.wait_drain = 1'b0;
		pending_items.push_back(it);
	endtask

	// One sprite as a run of rows; now and then the first or last mark is
	// dropped to get broken sequences. redraw repeats the previous sprite.
	task automatic queue_sprite(input bit redraw);
		int  n;
		bit  drop_first;
		bit  drop_last;
		if (!redraw || sprite_rows.size() == 0) begin
			sprite_x = 8'($urandom);
			sprite_y = 8'($urandom);
			n = $urandom_range(1, 16);
			sprite_rows.delete();
			for (int i = 0; i < n; i++)
				sprite_rows.push_back(8'($urandom));
		end
		n = sprite_rows.size();
		drop_first = ($urandom_range(0, 9) == 0);
		drop_last = ($urandom_range(0, 9) == 0);
		for (int i = 0; i < n; i++)
			queue_item(ACT_DRAW, sprite_x, sprite_y, 4'(i), sprite_rows[i],
				(i == 0) && !drop_first, (i == n - 1) && !drop_last);
	endtask

	task automatic build_stimulus();
		int  directed_n;
		int  r;
		// Directed: fresh screen, overlap, wrap at both edges, read marks,
		// empty row byte, sprites without a first row, extreme fields.
		queue_item(ACT_READ, 8'd0, 8'd0, 4'd0, 8'h00, 1'b0, 1'b0);
		queue_item(ACT_READ, 8'd63, 8'd31, 4'd0, 8'h00, 1'b0, 1'b0);
		queue_item(ACT_DRAW, 8'd0, 8'd0, 4'd0, 8'hff, 1'b1, 1'b0);
		queue_item(ACT_DRAW, 8'd0, 8'd0, 4'd1, 8'h80, 1'b0, 1'b1);
		queue_item(ACT_READ, 8'd0, 8'd0, 4'd0, 8'h00, 1'b0, 1'b0);
		queue_item(ACT_DRAW, 8'd0, 8'd0, 4'd0, 8'h81, 1'b1, 1'b0);
		queue_item(ACT_DRAW, 8'd0, 8'd0, 4'd1, 8'h80, 1'b0, 1'b1);
		queue_item(ACT_READ, 8'd255, 8'd255, 4'd15, 8'hff, 1'b1, 1'b1);
		queue_item(ACT_READ, 8'd64, 8'd32, 4'd0, 8'h00, 1'b0, 1'b1);
		queue_item(ACT_DRAW, 8'd5, 8'd5, 4'd0, 8'h00, 1'b1, 1'b1);
		queue_item(ACT_DRAW, 8'd60, 8'd30, 4'd15, 8'hff, 1'b1, 1'b1);
		queue_item(ACT_READ, 8'd192, 8'd77, 4'd0, 8'h00, 1'b0, 1'b0);
		queue_item(ACT_DRAW, 8'd255, 8'd255, 4'd15, 8'haa, 1'b1, 1'b0);
		queue_item(ACT_DRAW, 8'd255, 8'd255, 4'd15, 8'haa, 1'b0, 1'b1);
		queue_item(ACT_DRAW, 8'd100, 8'd100, 4'd0, 8'h3c, 1'b0, 1'b1);
		queue_item(ACT_DRAW, 8'd100, 8'd100, 4'd0, 8'h3c, 1'b0, 1'b1);
		queue_item(ACT_DRAW, 8'd255, 8'd255, 4'd15, 8'hff, 1'b1, 1'b1);
		queue_item(ACT_READ, 8'd0, 8'd14, 4'd0, 8'h00, 1'b1, 1'b0);
		queue_item(ACT_DRAW, 8'd127, 8'd128, 4'd8, 8'h55, 1'b1, 1'b1);
		directed_n = pending_items.size();

		// reads around the last sprite need a defined origin before any sprite
		sprite_x = 8'($urandom);
		sprite_y = 8'($urandom);

		// Random: mostly whole sprites, redraws to force collisions, reads
		// around the last sprite, and some raw noise.
		while (pending_items.size() < directed_n + RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 45)
				queue_sprite(1'b0);
			else if (r < 65)
				queue_sprite(1'b1);
			else if (r < 88)
				queue_item(ACT_READ, 8'(sprite_x + $urandom_range(0, 7)),
					8'(sprite_y + $urandom_range(0, 15)), 4'($urandom),
					8'($urandom), 1'($urandom), 1'($urandom));
			else
				queue_item(1'($urandom), 8'($urandom), 8'($urandom), 4'($urandom),
					8'($urandom), 1'($urandom), 1'($urandom));
		end

		// sender pauses until the pipe has drained
		pending_items[directed_n].wait_drain = 1'b1;
		pending_items[800].wait_drain = 1'b1;
	endtask

	// Request driver: valid stays up until the transfer happens.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
			req_if.action <= ACT_DRAW;
			req_if.x_pos <= '0;
			req_if.y_pos <= '0;
			req_if.row_offset <= '0;
			req_if.row_bits <= '0;
			req_if.first_row <= 1'b0;
			req_if.last_row <= 1'b0;
		end else begin
			if (req_if.valid && req_if.ready) begin
				expected_rsp.push_back(apply_sprite_item(cur_item));
				items_accepted++;
				if (cur_item.action == ACT_READ)
					read_count++;
				else
					draw_count++;
			end
			if (!req_if.valid || req_if.ready) begin
				if (pending_items.size() == 0) begin
					req_if.valid <= 1'b0;
				end else if (pending_items[0].wait_drain && expected_rsp.size() != 0) begin
					req_if.valid <= 1'b0;
				end else if (!(items_accepted >= CALM_LO && items_accepted < CALM_HI)
						&& $urandom_range(0, 99) < 10) begin
					req_if.valid <= 1'b0;
				end else begin
					cur_item = pending_items.pop_front();
					req_if.valid <= 1'b1;
					req_if.action <= cur_item.action;
					req_if.x_pos <= cur_item.x_pos;
					req_if.y_pos <= cur_item.y_pos;
					req_if.row_offset <= cur_item.row_offset;
					req_if.row_bits <= cur_item.row_bits;
					req_if.first_row <= cur_item.first_row;
					req_if.last_row <= cur_item.last_row;
				end
			end
		end
	end

	// Response monitor and sink: checks every transfer against the oldest
	// prediction, throttles ready, and once stalls for a long stretch.
	always @(posedge clk or negedge arst_n) begin
		pixel_rsp_t want;
		pixel_rsp_t got;
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			hold_left = 0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				got.collision = rsp_if.collision;
				got.pixel_value = rsp_if.pixel_value;
				got.draw_done = rsp_if.draw_done;
				results_seen++;
				if (got.collision)
					collision_hits++;
				if (got.pixel_value)
					lit_reads++;
				if (expected_rsp.size() == 0) begin
					error_count++;
					$display("%0t: unexpected result, collision=%b pixel_value=%b draw_done=%b",
						$time, got.collision, got.pixel_value, got.draw_done);
				end else begin
					want = expected_rsp.pop_front();
					if (got.collision !== want.collision) begin
						error_count++;
						$display("%0t: collision mismatch, expected %b, actual %b",
							$time, want.collision, got.collision);
					end
					if (got.pixel_value !== want.pixel_value) begin
						error_count++;
						$display("%0t: pixel_value mismatch, expected %b, actual %b",
							$time, want.pixel_value, got.pixel_value);
					end
					if (got.draw_done !== want.draw_done) begin
						error_count++;
						$display("%0t: draw_done mismatch, expected %b, actual %b",
							$time, want.draw_done, got.draw_done);
					end
				end
			end
			// long back-pressure so the block fills and stalls its input
			if (!hold_done && results_seen >= RSP_HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = RSP_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else if (!(results_seen >= CALM_LO && results_seen < CALM_HI)
					&& $urandom_range(0, 99) < 10) begin
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		for (int i = 0; i < SCREEN_HEIGHT; i++)
			screen_lines[i] = '0;
		shadow_collision = 1'b0;
		build_stimulus();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_items.size() != 0 || req_if.valid || expected_rsp.size() != 0)
			@(posedge clk);
		// the extra edges after the drain catch any stray result
		repeat (8) @(posedge clk);
		$display("Covered %0d sprite rows and %0d pixel reads, %0d results in total.",
			draw_count, read_count, results_seen);
		$display("Results with collision set: %0d, reads of lit pixels: %0d.",
			collision_hits, lit_reads);
		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// hard stop, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("Timeout with %0d results still expected.", expected_rsp.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire
